// ===== hdl/ddps_pkg.sv =====
// Shared types, constants and the quarter-wave cosine lookup for the powder-sum block.
`timescale 1ns / 1ps
package ddps_pkg;

  // Frequency scale, about 1000 * 2^39 / (2 pi), split for two narrow multiplies.
  localparam logic [63:0] FREQ_SCALE = 64'd87496355273783;
  localparam logic [23:0] FS_LO = 24'(FREQ_SCALE % 64'd16777216);
  localparam logic [22:0] FS_HI = 23'(FREQ_SCALE / 64'd16777216);
  localparam logic [15:0] CC_RESET = 16'd41738;

  // Widths of the datapath.
  localparam int NUM_W = 63;
  localparam int DEN_W = 48;
  localparam int FP_W = 53;
  localparam int SUM_W = 23;

  // One divider stage's payload.
  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic [DEN_W-1:0] rem;
    logic [NUM_W-1:0] quo;
    logic [15:0]      tp;
    logic             inv;
  } div_t;

  // Payload handed from one bin cell to the next.
  typedef struct packed {
    logic [FP_W-1:0]         fp;
    logic signed [SUM_W-1:0] sum;
    logic                    inv;
  } cell_bus_t;

  // cos(i * pi / 512) in Q1.14, i = 0..256.
  localparam logic [14:0] QCOS [257] = '{
    16384, 16384, 16383, 16382, 16379, 16376, 16372, 16368, 16364, 16358,
    16353, 16346, 16339, 16331, 16323, 16314, 16305, 16294, 16284, 16272,
    16260, 16248, 16234, 16221, 16206, 16191, 16175, 16159, 16142, 16125,
    16107, 16088, 16069, 16049, 16028, 16007, 15985, 15963, 15940, 15917,
    15893, 15868, 15842, 15817, 15790, 15763, 15735, 15707, 15678, 15649,
    15618, 15588, 15557, 15525, 15492, 15459, 15426, 15392, 15357, 15322,
    15286, 15249, 15212, 15175, 15137, 15098, 15059, 15019, 14978, 14937,
    14896, 14854, 14811, 14768, 14724, 14680, 14635, 14589, 14543, 14497,
    14449, 14402, 14354, 14305, 14256, 14206, 14155, 14104, 14053, 14001,
    13949, 13896, 13842, 13788, 13733, 13678, 13623, 13567, 13510, 13453,
    13395, 13337, 13279, 13219, 13160, 13100, 13039, 12978, 12916, 12854,
    12792, 12729, 12665, 12601, 12537, 12472, 12406, 12340, 12274, 12207,
    12140, 12072, 12004, 11935, 11866, 11797, 11727, 11656, 11585, 11514,
    11442, 11370, 11297, 11224, 11151, 11077, 11003, 10928, 10853, 10778,
    10702, 10625, 10549, 10471, 10394, 10316, 10238, 10159, 10080, 10001,
     9921,  9841,  9760,  9679,  9598,  9516,  9434,  9352,  9269,  9186,
     9102,  9019,  8935,  8850,  8765,  8680,  8595,  8509,  8423,  8337,
     8250,  8163,  8076,  7988,  7900,  7812,  7723,  7635,  7545,  7456,
     7366,  7276,  7186,  7096,  7005,  6914,  6823,  6731,  6639,  6547,
     6455,  6363,  6270,  6177,  6084,  5990,  5897,  5803,  5708,  5614,
     5520,  5425,  5330,  5235,  5139,  5044,  4948,  4852,  4756,  4660,
     4563,  4467,  4370,  4273,  4176,  4078,  3981,  3883,  3786,  3688,
     3590,  3492,  3393,  3295,  3197,  3098,  2999,  2900,  2801,  2702,
     2603,  2503,  2404,  2305,  2205,  2105,  2006,  1906,  1806,  1706,
     1606,  1506,  1406,  1306,  1205,  1105,  1005,   904,   804,   704,
      603,   503,   402,   302,   201,   101,     0
  };

  // Cosine of a phase in unsigned Q0.32 turns, rounded to 1024 steps per turn.
  function automatic logic signed [15:0] cos_turns(input logic [31:0] turns);
    logic [10:0] rnd;
    logic [9:0]  idx;
    logic [8:0]  r;
    logic [8:0]  rc;
    logic signed [15:0] a;
    logic signed [15:0] b;
    rnd = turns[31:21] + 11'd1;
    idx = rnd[10:1];
    r   = {1'b0, idx[7:0]};
    rc  = 9'd256 - r;
    a   = $signed({1'b0, QCOS[r]});
    b   = $signed({1'b0, QCOS[rc]});
    case (idx[9:8])
      2'd0:    cos_turns = a;
      2'd1:    cos_turns = -b;
      2'd2:    cos_turns = -a;
      default: cos_turns = b;
    endcase
  endfunction

endpackage

// ===== hdl/ddps_div_stage.sv =====
// One restoring divider stage: retires one quotient bit per cycle while en is high.
`timescale 1ns / 1ps
module ddps_div_stage
  import ddps_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic vin,
  input  div_t din,
  output logic vout,
  output div_t dout
);

  logic [DEN_W:0] trial;
  logic [DEN_W:0] diff;
  logic           ge;
  div_t           nxt;

  // Shift in the next numerator bit and subtract the divisor when it fits.
  always_comb begin
    trial = {din.rem, din.num[NUM_W-1]};
    diff  = trial - {1'b0, din.den};
    ge    = trial >= {1'b0, din.den};
    nxt     = din;
    nxt.num = {din.num[NUM_W-2:0], 1'b0};
    nxt.rem = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    nxt.quo = {din.quo[NUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nxt;
    end
  end

endmodule

// ===== hdl/ddps_cell.sv =====
// One orientation bin: phase product, cosine lookup and running-sum update.
`timescale 1ns / 1ps
module ddps_cell
  import ddps_pkg::*;
#(
  parameter int K = 0,
  parameter int M = 200
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  logic      vin,
  input  cell_bus_t din,
  output logic      vout,
  output cell_bus_t dout
);

  // Orientation factor (1 - 3 x^2) in signed Q.20, rounded half up.
  localparam logic [63:0] KK = 64'(K);
  localparam logic [63:0] MM = 64'(M);
  localparam logic [63:0] H = (KK * KK * 64'd6 * 64'd1048576 + MM * MM) / (64'd2 * MM * MM);
  localparam logic [63:0] G64 = 64'd1048576 - H;
  localparam logic signed [21:0] G = $signed(G64[21:0]);

  logic                    v1;
  cell_bus_t               b1;
  logic signed [49:0]      pa;
  logic signed [48:0]      pb;
  logic [FP_W-1:0]         ph;
  logic signed [15:0]      cv;

  // First stage: two partial products of the phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1 <= din;
      pa <= 50'($signed({1'b0, din.fp[26:0]})) * 50'(G);
      pb <= 49'($signed({1'b0, din.fp[52:27]})) * 49'(G);
    end
  end

  // Second stage: combine modulo 2^53, look up the cosine, add it on.
  always_comb begin
    ph = FP_W'(pa) + {pb[25:0], 27'd0};
    cv = cos_turns(ph[52:21]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout.fp  <= b1.fp;
      dout.inv <= b1.inv;
      dout.sum <= b1.sum + SUM_W'(cv);
    end
  end

endmodule

// ===== hdl/dipolar_decay_powder_sum_top.sv =====
// Top level of the dipolar decay powder sum: frequency divider, phase product, bin cells.
//
//   channel  direction  handshake             payload
//   s_*      in         s_tvalid / s_tready   s_tdata: distance, time_point
//   m_*      out        m_tvalid / m_tready   m_tdata: decay_sum; m_tuser: invalid
//   cfg_*    in         cfg_valid / cfg_ready cfg_data: coupling_constant
//
// One item enters per cycle unless the pipeline stalls; an item passes the front stages,
// the 63-stage restoring divider, the phase stages and the two-stage bin cells.
// rst is synchronous; it clears all valid bits and loads the coupling constant.
// A waiting result only stalls the pipeline when the last cell also holds an item;
// bubbles keep moving, so input is taken while a result waits in the output register.
`timescale 1ns / 1ps
module dipolar_decay_powder_sum_top
  import ddps_pkg::*;
#(
  parameter int NUM_BINS = 201
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [15:0] distance, [31:16] time_point
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [22:0] decay_sum, [23] zero
  output logic [0:0]  m_tuser,   // [0] invalid
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data   // [15:0] coupling_constant
);

  logic [15:0] coupling_constant;
  logic        en;
  logic        acc;
  logic        last_v;

  // Front stages.
  logic        v_f1, v_f2;
  logic [15:0] d_f1, p_f1;
  logic [31:0] dd_f1;
  logic [39:0] nlo_f1;
  logic [38:0] nhi_f1;
  logic        inv_f1;
  div_t        f2;

  // Divider chain.
  logic        dv [NUM_W+1];
  div_t        dd [NUM_W+1];

  // Phase product stages.
  logic        v_m1, v_m2;
  logic [47:0] lo_m1;
  logic [46:0] hi_m1;
  logic [NUM_W-1:0] freq_m1;
  logic        neg_m1, inv_m1;
  cell_bus_t   m2;

  // Bin cells.
  logic        cv [NUM_BINS+1];
  cell_bus_t   cb [NUM_BINS+1];

  logic [SUM_W-1:0] sum_out;
  logic             inv_out;

  assign cfg_ready = 1'b1;
  assign last_v    = cv[NUM_BINS];
  assign en        = !m_tvalid || m_tready || !last_v;
  assign s_tready  = en;
  assign acc       = s_tvalid && s_tready;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      coupling_constant <= CC_RESET;
    end else if (cfg_valid && cfg_ready) begin
      coupling_constant <= cfg_data;
    end
  end

  // Valid bits of the front and phase stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v_f1 <= 1'b0;
      v_f2 <= 1'b0;
      v_m1 <= 1'b0;
      v_m2 <= 1'b0;
    end else if (en) begin
      v_f1 <= acc;
      v_f2 <= v_f1;
      v_m1 <= dv[NUM_W];
      v_m2 <= v_m1;
    end
  end

  // Square of the distance and the scaled numerator in two halves.
  always_ff @(posedge clk) begin
    if (en) begin
      d_f1   <= s_tdata[15:0];
      p_f1   <= s_tdata[31:16];
      dd_f1  <= 32'(s_tdata[15:0]) * 32'(s_tdata[15:0]);
      nlo_f1 <= 40'(coupling_constant) * 40'(FS_LO);
      nhi_f1 <= 39'(coupling_constant) * 39'(FS_HI);
      inv_f1 <= s_tdata[15:0] == 16'd0;
    end
  end

  // Cube of the distance and the full numerator.
  always_ff @(posedge clk) begin
    if (en) begin
      f2.den <= 48'(dd_f1) * 48'(d_f1);
      f2.num <= {nhi_f1[38:0], 24'd0} + NUM_W'(nlo_f1);
      f2.rem <= '0;
      f2.quo <= '0;
      f2.tp  <= p_f1;
      f2.inv <= inv_f1;
    end
  end

  assign dv[0] = v_f2;
  assign dd[0] = f2;

  for (genvar i = 0; i < NUM_W; i++) begin : g_div
    ddps_div_stage u_stage (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .vin  (dv[i]),
      .din  (dd[i]),
      .vout (dv[i+1]),
      .dout (dd[i+1])
    );
  end

  // Frequency times time, split into two products of 48 and 47 bits.
  always_ff @(posedge clk) begin
    if (en) begin
      freq_m1 <= dd[NUM_W].quo;
      lo_m1   <= 48'(dd[NUM_W].quo[31:0]) * 48'(dd[NUM_W].tp);
      hi_m1   <= 47'(dd[NUM_W].quo[62:32]) * 47'(dd[NUM_W].tp);
      neg_m1  <= dd[NUM_W].tp[15];
      inv_m1  <= dd[NUM_W].inv;
    end
  end

  // Signed correction and wrap to the 53 fraction-of-turn bits.
  always_ff @(posedge clk) begin
    if (en) begin
      m2.fp  <= FP_W'(lo_m1) + {hi_m1[20:0], 32'd0}
                - (neg_m1 ? {freq_m1[36:0], 16'd0} : {FP_W{1'b0}});
      m2.sum <= '0;
      m2.inv <= inv_m1;
    end
  end

  assign cv[0] = v_m2;
  assign cb[0] = m2;

  for (genvar k = 0; k < NUM_BINS; k++) begin : g_cell
    ddps_cell #(
      .K (k),
      .M (NUM_BINS - 1)
    ) u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .vin  (cv[k]),
      .din  (cb[k]),
      .vout (cv[k+1]),
      .dout (cb[k+1])
    );
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (last_v && en) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (last_v && en) begin
      sum_out <= cb[NUM_BINS].inv ? '0 : cb[NUM_BINS].sum;
      inv_out <= cb[NUM_BINS].inv;
    end
  end

  assign m_tdata = {1'b0, sum_out};
  assign m_tuser = inv_out;

  // A zero distance always reports a zero sum.
  a_inv_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata[22:0] == 23'd0))
    else $error("invalid result with nonzero sum");

  // Input is held off only when the last cell and the output register are both full.
  a_stall: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready && last_v) |-> !s_tready)
    else $error("input taken while pipeline is blocked");

  // A waiting result is never overwritten.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(sum_out)))
    else $error("waiting result changed");

  // Nothing leaves right after reset.
  a_reset: assert property (@(posedge clk) (!rst && $past(rst)) |-> !m_tvalid)
    else $error("output valid right after reset");

endmodule
